// File: hw/rtl/cau_pkg.sv
// Shared operation codes for the complex arithmetic unit.
package cau_pkg;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

endpackage

// File: hw/rtl/cau_front.sv
// Front end: products, sums, add/sub/mul results and divider operands (two stages).
module cau_front #(
  parameter int DW = 16,
  parameter int F  = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [1:0]            op,
  input  logic signed [DW-1:0]  ar,
  input  logic signed [DW-1:0]  ai,
  input  logic signed [DW-1:0]  br,
  input  logic signed [DW-1:0]  bi,
  output logic                  out_valid,
  output logic [1:0]            out_op,
  output logic [DW-1:0]         fast_re,
  output logic [DW-1:0]         fast_im,
  output logic                  fast_ovf,
  output logic [2*DW+F-1:0]     num_re,
  output logic [2*DW+F-1:0]     num_im,
  output logic                  sgn_re,
  output logic                  sgn_im,
  output logic [2*DW-1:0]       den,
  output logic                  dz
);
  import cau_pkg::*;

  localparam int PW  = 2 * DW;
  localparam int NMW = PW + F;

  // {ovf, value}: clamp a wide signed value to DW bits
  function automatic logic [DW:0] sat(input logic signed [PW:0] v);
    logic ok;
    ok = (v[PW:DW-1] == '0) || (v[PW:DW-1] == '1);
    if (ok) return {1'b0, v[DW-1:0]};
    else if (v[PW]) return {1'b1, 1'b1, {(DW-1){1'b0}}};
    else return {1'b1, 1'b0, {(DW-1){1'b1}}};
  endfunction

  // stage 1
  logic                 v1;
  logic [1:0]           op1;
  logic signed [DW:0]   add_re, add_im, sub_re, sub_im;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir, sq_r, sq_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1    <= op;
      add_re <= (DW+1)'(ar) + (DW+1)'(br);
      add_im <= (DW+1)'(ai) + (DW+1)'(bi);
      sub_re <= (DW+1)'(ar) - (DW+1)'(br);
      sub_im <= (DW+1)'(ai) - (DW+1)'(bi);
      p_rr   <= PW'(ar) * PW'(br);
      p_ii   <= PW'(ai) * PW'(bi);
      p_ri   <= PW'(ar) * PW'(bi);
      p_ir   <= PW'(ai) * PW'(br);
      sq_r   <= PW'(br) * PW'(br);
      sq_i   <= PW'(bi) * PW'(bi);
    end
  end

  // stage 2 combinational
  logic signed [PW:0] mul_re, mul_im, dn_re, dn_im;
  logic [DW:0]        s_re, s_im;
  logic [PW-1:0]      mag_re, mag_im, den_c;

  always_comb begin
    mul_re = (PW+1)'(p_rr) - (PW+1)'(p_ii);
    mul_im = (PW+1)'(p_ri) + (PW+1)'(p_ir);
    dn_re  = (PW+1)'(p_rr) + (PW+1)'(p_ii);
    dn_im  = (PW+1)'(p_ir) - (PW+1)'(p_ri);
    mag_re = dn_re[PW] ? PW'(-dn_re) : PW'(dn_re);
    mag_im = dn_im[PW] ? PW'(-dn_im) : PW'(dn_im);
    den_c  = $unsigned(sq_r) + $unsigned(sq_i);
    case (op1)
      OP_ADD: begin
        s_re = sat((PW+1)'(add_re));
        s_im = sat((PW+1)'(add_im));
      end
      OP_SUB: begin
        s_re = sat((PW+1)'(sub_re));
        s_im = sat((PW+1)'(sub_im));
      end
      OP_MUL: begin
        s_re = sat(mul_re >>> F);
        s_im = sat(mul_im >>> F);
      end
      default: begin
        s_re = '0;
        s_im = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_op   <= op1;
      fast_re  <= s_re[DW-1:0];
      fast_im  <= s_im[DW-1:0];
      fast_ovf <= s_re[DW] | s_im[DW];
      num_re   <= NMW'(mag_re) << F;
      num_im   <= NMW'(mag_im) << F;
      sgn_re   <= dn_re[PW];
      sgn_im   <= dn_im[PW];
      den      <= den_c;
      dz       <= (den_c == '0);
    end
  end

endmodule

// File: hw/rtl/cau_div_step.sv
// One restoring-division step for both quotient lanes, with sideband carried along.
module cau_div_step #(
  parameter int RW    = 48,
  parameter int DENW  = 32,
  parameter int QW    = 16,
  parameter int SHIFT = 0,
  parameter int SW    = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [RW-1:0]   in_rem_re,
  input  logic [RW-1:0]   in_rem_im,
  input  logic [QW-1:0]   in_q_re,
  input  logic [QW-1:0]   in_q_im,
  input  logic [DENW-1:0] in_den,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [RW-1:0]   out_rem_re,
  output logic [RW-1:0]   out_rem_im,
  output logic [QW-1:0]   out_q_re,
  output logic [QW-1:0]   out_q_im,
  output logic [DENW-1:0] out_den,
  output logic [SW-1:0]   out_side
);

  logic [RW-1:0] dsh;
  logic          ge_re, ge_im;

  assign dsh   = RW'(in_den) << SHIFT;
  assign ge_re = (in_rem_re >= dsh);
  assign ge_im = (in_rem_im >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem_re <= ge_re ? in_rem_re - dsh : in_rem_re;
      out_rem_im <= ge_im ? in_rem_im - dsh : in_rem_im;
      out_q_re   <= in_q_re | (QW'(ge_re) << SHIFT);
      out_q_im   <= in_q_im | (QW'(ge_im) << SHIFT);
      out_den    <= in_den;
      out_side   <= in_side;
    end
  end

endmodule

// File: hw/rtl/complex_arithmetic_unit.sv
// Top level of the complex arithmetic unit: add, subtract, multiply, divide.
//
// Usage:
//  - Input stream: s_axis_tuser carries the operation (add, subtract,
//    multiply, divide); s_axis_tdata carries a_re, a_im, b_re, b_im, each
//    signed fixed point with FRAC_BITS fraction bits.
//  - Output stream: m_axis_tdata carries res_re, res_im (saturated);
//    m_axis_tuser carries overflow and div_zero.
//  - One request per cycle is accepted and one result per cycle leaves while the receiver does not stall.
//  - The pipeline has two front stages (products, then sums and saturation),
//    one overflow-check stage, one restoring-division step per quotient bit,
//    and the output register.
//  - All operations go through the same pipeline, so results leave in order.
//  - When the receiver stalls, the whole pipeline freezes and s_axis_tready
//    drops in the same cycle; nothing is lost or repeated.
//  - Reset clears every valid bit; the data registers are not reset.
//  - A divide with a zero divisor returns zero with div_zero set.
module complex_arithmetic_unit #(
  parameter int FRAC_BITS  = 8,
  parameter int DATA_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // a_re, a_im, b_re, b_im
  input  logic [((4*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // req_type
  input  logic [1:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // res_re, res_im
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // overflow, div_zero
  output logic [1:0] m_axis_tuser
);
  import cau_pkg::*;

  localparam int DW   = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int PW   = 2 * DW;
  localparam int NMW  = PW + F;
  localparam int RW   = PW + DW + F;
  localparam int OTW  = ((2*DATA_WIDTH+7)/8)*8;

  typedef struct packed {
    logic [1:0]    op;
    logic [DW-1:0] fast_re;
    logic [DW-1:0] fast_im;
    logic          fast_ovf;
    logic          dz;
    logic          sgn_re;
    logic          sgn_im;
    logic          ov_re;
    logic          ov_im;
  } side_t;

  localparam int SW = $bits(side_t);

  // whole pipeline advances together unless the output is held
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // front end
  logic             f_valid, f_ovf, f_sre, f_sim, f_dz;
  logic [1:0]       f_op;
  logic [DW-1:0]    f_re, f_im;
  logic [NMW-1:0]   f_nre, f_nim;
  logic [PW-1:0]    f_den;

  cau_front #(.DW(DW), .F(F)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .op        (s_axis_tuser),
    .ar        (s_axis_tdata[DW-1:0]),
    .ai        (s_axis_tdata[2*DW-1:DW]),
    .br        (s_axis_tdata[3*DW-1:2*DW]),
    .bi        (s_axis_tdata[4*DW-1:3*DW]),
    .out_valid (f_valid),
    .out_op    (f_op),
    .fast_re   (f_re),
    .fast_im   (f_im),
    .fast_ovf  (f_ovf),
    .num_re    (f_nre),
    .num_im    (f_nim),
    .sgn_re    (f_sre),
    .sgn_im    (f_sim),
    .den       (f_den),
    .dz        (f_dz)
  );

  // overflow check: quotient magnitude >= 2^DW saturates regardless of sign
  logic          d_valid [0:DW];
  logic [RW-1:0] d_rre   [0:DW];
  logic [RW-1:0] d_rim   [0:DW];
  logic [DW-1:0] d_qre   [0:DW];
  logic [DW-1:0] d_qim   [0:DW];
  logic [PW-1:0] d_den   [0:DW];
  logic [SW-1:0] d_side  [0:DW];
  side_t         s3;
  logic [RW-1:0] lim;

  assign lim = RW'(f_den) << DW;

  always_comb begin
    s3.op       = f_op;
    s3.fast_re  = f_re;
    s3.fast_im  = f_im;
    s3.fast_ovf = f_ovf;
    s3.dz       = f_dz;
    s3.sgn_re   = f_sre;
    s3.sgn_im   = f_sim;
    s3.ov_re    = (RW'(f_nre) >= lim);
    s3.ov_im    = (RW'(f_nim) >= lim);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid[0] <= 1'b0;
    end else if (en) begin
      d_valid[0] <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_rre[0]  <= RW'(f_nre);
      d_rim[0]  <= RW'(f_nim);
      d_qre[0]  <= '0;
      d_qim[0]  <= '0;
      d_den[0]  <= f_den;
      d_side[0] <= s3;
    end
  end

  // one quotient bit per stage, MSB first
  for (genvar k = 0; k < DW; k++) begin : g_div
    cau_div_step #(
      .RW(RW), .DENW(PW), .QW(DW), .SHIFT(DW-1-k), .SW(SW)
    ) u_step (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .in_valid   (d_valid[k]),
      .in_rem_re  (d_rre[k]),
      .in_rem_im  (d_rim[k]),
      .in_q_re    (d_qre[k]),
      .in_q_im    (d_qim[k]),
      .in_den     (d_den[k]),
      .in_side    (d_side[k]),
      .out_valid  (d_valid[k+1]),
      .out_rem_re (d_rre[k+1]),
      .out_rem_im (d_rim[k+1]),
      .out_q_re   (d_qre[k+1]),
      .out_q_im   (d_qim[k+1]),
      .out_den    (d_den[k+1]),
      .out_side   (d_side[k+1])
    );
  end

  // final: sign, saturation, select
  side_t         sl;
  logic [DW-1:0] half, q_re, q_im, r_re, r_im;
  logic          sat_re, sat_im, ovf_c, dz_c;

  always_comb begin
    sl     = d_side[DW];
    half   = DW'(1) << (DW-1);
    q_re   = d_qre[DW];
    q_im   = d_qim[DW];
    sat_re = sl.ov_re || (sl.sgn_re ? (q_re > half) : (q_re >= half));
    sat_im = sl.ov_im || (sl.sgn_im ? (q_im > half) : (q_im >= half));
    dz_c   = 1'b0;
    if (sl.op == OP_DIV) begin
      if (sl.dz) begin
        r_re  = '0;
        r_im  = '0;
        ovf_c = 1'b0;
        dz_c  = 1'b1;
      end else begin
        r_re  = sat_re ? (sl.sgn_re ? half : ~half) : (sl.sgn_re ? -q_re : q_re);
        r_im  = sat_im ? (sl.sgn_im ? half : ~half) : (sl.sgn_im ? -q_im : q_im);
        ovf_c = sat_re | sat_im;
      end
    end else begin
      r_re  = sl.fast_re;
      r_im  = sl.fast_im;
      ovf_c = sl.fast_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= d_valid[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= OTW'({r_im, r_re});
      m_axis_tuser <= {dz_c, ovf_c};
    end
  end

  // a zero divisor never reports overflow
  a_dz_no_ovf: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
    else $error("div_zero with overflow");

  // a zero divisor gives a zero result
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[2*DW-1:0] == '0)
    else $error("div_zero with nonzero result");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid && !d_valid[0])
    else $error("valid after reset");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the complex arithmetic unit: random and directed operand streams.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cau_pkg::*;

  localparam int FRAC = 8;
  localparam int DW = 16;
  localparam int WATCHDOG_CYCLES = 20000;

  typedef struct packed {
    logic [15:0] re;
    logic [15:0] im;
    logic ovf;
    logic dz;
  } cplx_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // a_re, a_im, b_re, b_im
  logic [1:0] s_axis_tuser = OP_ADD; // req_type
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // res_re, res_im
  logic [1:0] m_axis_tuser;         // overflow, div_zero

  cplx_result_t pending_results[$];
  int error_count = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;   // long receiver stall request

  complex_arithmetic_unit #(.FRAC_BITS(FRAC), .DATA_WIDTH(DW)) DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Clamp to the signed 16-bit range and flag it.
  function automatic logic [15:0] clamp16(input longint v, inout logic ovf);
    if (v > 32767) begin
      ovf = 1'b1;
      return 16'h7fff;
    end
    if (v < -32768) begin
      ovf = 1'b1;
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  function automatic cplx_result_t compute_result(input logic [1:0] op,
      input logic signed [15:0] ar, ai, br, bi);
    cplx_result_t r;
    longint den, nr, ni;
    r = '0;
    case (op)
      OP_ADD: begin
        r.re = clamp16(longint'(ar) + br, r.ovf);
        r.im = clamp16(longint'(ai) + bi, r.ovf);
      end
      OP_SUB: begin
        r.re = clamp16(longint'(ar) - br, r.ovf);
        r.im = clamp16(longint'(ai) - bi, r.ovf);
      end
      OP_MUL: begin
        // arithmetic shift floors toward minus infinity
        r.re = clamp16((longint'(ar) * br - longint'(ai) * bi) >>> FRAC, r.ovf);
        r.im = clamp16((longint'(ar) * bi + longint'(ai) * br) >>> FRAC, r.ovf);
      end
      default: begin
        den = longint'(br) * br + longint'(bi) * bi;
        if (den == 0) begin
          r.dz = 1'b1;
        end else begin
          nr = (longint'(ar) * br + longint'(ai) * bi) * (64'sd1 <<< FRAC);
          ni = (longint'(ai) * br - longint'(ar) * bi) * (64'sd1 <<< FRAC);
          r.re = clamp16(nr / den, r.ovf);  // SV division truncates toward zero
          r.im = clamp16(ni / den, r.ovf);
        end
      end
    endcase
    return r;
  endfunction

  // Sender bursts of random length, sometimes separated by a random gap.
  int burst_left = 0;

  task automatic send_request(input logic [1:0] op, input logic [15:0] ar, ai, br, bi);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 2) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {bi, br, ai, ar};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results.push_back(compute_result(op, ar, ai, br, bi));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 1023)) - 512);  // small, near zero
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic [15:0] ext[4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    send_request(OP_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);  // both parts clamp
    send_request(OP_ADD, 16'h0100, 16'hff00, 16'h0080, 16'h0100);
    send_request(OP_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_request(OP_SUB, 16'h0000, 16'h0000, 16'h8000, 16'h0001);
    send_request(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_request(OP_MUL, 16'h0100, 16'h0000, 16'hffff, 16'h0000);  // negative product
    send_request(OP_MUL, 16'h0180, 16'hfe80, 16'h0200, 16'h0100);
    send_request(OP_DIV, 16'h1234, 16'h5678, 16'h0000, 16'h0000);  // zero divisor
    send_request(OP_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_request(OP_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000);  // huge quotient
    send_request(OP_DIV, 16'hff00, 16'h0100, 16'h0300, 16'h0000);  // truncation toward zero
    send_request(OP_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_request(OP_DIV, 16'h0100, 16'h0000, 16'h0000, 16'hff00);
    for (int k = 0; k < 4; k++)
      send_request(2'(k), ext[k], ext[3-k], ext[(k+1)%4], ext[(k+2)%4]);
    drain_results();
  endtask

  task automatic test_random(input int count);
    for (int k = 0; k < count; k++)
      send_request(2'($urandom), rand_operand(), rand_operand(), rand_operand(), rand_operand());
    drain_results();
  endtask

  // Long receiver stall while the sender keeps offering, so the pipeline backs up.
  task automatic test_backpressure();
    hold_off = 1'b1;
    test_random(80);
  endtask

  // Receiver stall pattern plus the long hold-off, counted here.
  always @(posedge clk) begin
    if (hold_off) begin
      m_axis_tready <= 1'b0;
      repeat (300) @(posedge clk);
      hold_off = 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 99) < 30);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    cplx_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: re=%h im=%h user=%b", $realtime,
                 m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[15:0] !== want.re) begin
          $display("%0t: res_re expected %h actual %h", $realtime, want.re, m_axis_tdata[15:0]);
          error_count++;
        end
        if (m_axis_tdata[31:16] !== want.im) begin
          $display("%0t: res_im expected %h actual %h", $realtime, want.im, m_axis_tdata[31:16]);
          error_count++;
        end
        if (m_axis_tuser[0] !== want.ovf) begin
          $display("%0t: overflow expected %b actual %b", $realtime, want.ovf, m_axis_tuser[0]);
          error_count++;
        end
        if (m_axis_tuser[1] !== want.dz) begin
          $display("%0t: div_zero expected %b actual %b", $realtime, want.dz, m_axis_tuser[1]);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(600);
    test_backpressure();
    test_random(600);
    if (pending_results.size() != 0 || error_count != 0) begin
      if (pending_results.size() != 0)
        $display("%0t: %0d results never arrived", $realtime, pending_results.size());
      $display("Regression FAIL");
    end else begin
      $display("Regression PASS");
    end
    $finish;
  end
endmodule
